/* sv/four_level_page_table_walker_core_assert.svh */
// ----------------------------------------------------------------------------
// four-level page table walker assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// checked out of reset only
`define FLPTW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("flptw assertion failed");
// checked at every edge, reset included
`define FLPTW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("flptw assertion failed");
`else
`define FLPTW_ASSERT(lbl, prop)
`define FLPTW_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* sv/flptw_pkg.sv */
// ----------------------------------------------------------------------------
// flptw_pkg
// shared widths, codes and item types of the page table walker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package flptw_pkg;

  localparam int unsigned VA_W    = 48;
  localparam int unsigned RA_W    = 52;
  localparam int unsigned PA_W    = 41;
  localparam int unsigned ENTRY_W = 64;

  // present and page size bits of a pde
  localparam logic [7:0] LARGE_BITS = 8'h81;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_RESP  = 1'b1
  } func_e;

  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_DONE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_LARGE  = 2'd2,
    ST_STRAY  = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    LVL_IDLE = 5'b00001,
    LVL_PML4 = 5'b00010,
    LVL_PDPT = 5'b00100,
    LVL_PD   = 5'b01000,
    LVL_PT   = 5'b10000
  } level_e;

  typedef struct packed {
    func_e               func;
    logic [VA_W-1:0]     virt_addr;
    logic [RA_W-1:0]     root_table;
    logic [ENTRY_W-1:0]  entry_data;
  } in_item_t;

  typedef struct packed {
    kind_e           kind;
    logic [RA_W-1:0] read_address;
    logic [PA_W-1:0] phys_addr;
    status_e         status;
  } out_item_t;

  typedef struct packed {
    level_e          level;
    logic [VA_W-1:0] vaddr;
  } walk_state_t;

endpackage

/* sv/flptw_in_if.sv */
// ----------------------------------------------------------------------------
// flptw_in_if
// request and memory response channel into the walker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface flptw_in_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic [flptw_pkg::VA_W-1:0]      virt_addr;
  logic [flptw_pkg::RA_W-1:0]      root_table;
  logic [flptw_pkg::ENTRY_W-1:0]   entry_data;

  modport source (output valid, func, virt_addr, root_table, entry_data, input ready);
  modport sink (input valid, func, virt_addr, root_table, entry_data, output ready);
endinterface

/* sv/flptw_out_if.sv */
// ----------------------------------------------------------------------------
// flptw_out_if
// read request and completion channel out of the walker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface flptw_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [flptw_pkg::RA_W-1:0]   read_address;
  logic [flptw_pkg::PA_W-1:0]   phys_addr;
  logic [1:0]                   status;

  modport source (output valid, kind, read_address, phys_addr, status, input ready);
  modport sink (input valid, kind, read_address, phys_addr, status, output ready);
endinterface

/* sv/flptw_step.sv */
// ----------------------------------------------------------------------------
// flptw_step
// one walk step: next read address or final translation, next level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flptw_step (
  input  flptw_pkg::in_item_t    item_i,
  input  flptw_pkg::walk_state_t state_i,
  output flptw_pkg::walk_state_t state_o,
  output flptw_pkg::out_item_t   result_o
);

  logic [28:0] large_frame;

  // 2 mb page: 4 kb index added to the 28-bit frame field
  assign large_frame = {20'd0, state_i.vaddr[20:12]} + {1'b0, item_i.entry_data[39:12]};

  always_comb begin
    state_o  = state_i;
    result_o = '{kind: flptw_pkg::KIND_READ, read_address: '0, phys_addr: '0,
                 status: flptw_pkg::ST_OK};

    if (item_i.func == flptw_pkg::FUNC_START) begin
      state_o.vaddr         = item_i.virt_addr;
      state_o.level         = flptw_pkg::LVL_PML4;
      result_o.read_address = {item_i.root_table[51:12], item_i.virt_addr[47:39], 3'b000};
    end else if (state_i.level == flptw_pkg::LVL_IDLE) begin
      result_o.kind   = flptw_pkg::KIND_DONE;
      result_o.status = flptw_pkg::ST_STRAY;
    end else if (!item_i.entry_data[0]) begin
      state_o.level   = flptw_pkg::LVL_IDLE;
      result_o.kind   = flptw_pkg::KIND_DONE;
      result_o.status = flptw_pkg::ST_ABSENT;
    end else begin
      unique case (state_i.level)
        flptw_pkg::LVL_PML4: begin
          state_o.level         = flptw_pkg::LVL_PDPT;
          result_o.read_address = {item_i.entry_data[51:12], state_i.vaddr[38:30], 3'b000};
        end
        flptw_pkg::LVL_PDPT: begin
          state_o.level         = flptw_pkg::LVL_PD;
          result_o.read_address = {item_i.entry_data[51:12], state_i.vaddr[29:21], 3'b000};
        end
        flptw_pkg::LVL_PD: begin
          if ((item_i.entry_data[7:0] & flptw_pkg::LARGE_BITS) == flptw_pkg::LARGE_BITS) begin
            state_o.level      = flptw_pkg::LVL_IDLE;
            result_o.kind      = flptw_pkg::KIND_DONE;
            result_o.status    = flptw_pkg::ST_LARGE;
            result_o.phys_addr = {large_frame, state_i.vaddr[11:0]};
          end else begin
            state_o.level         = flptw_pkg::LVL_PT;
            result_o.read_address = {item_i.entry_data[51:12], state_i.vaddr[20:12], 3'b000};
          end
        end
        flptw_pkg::LVL_PT: begin
          state_o.level      = flptw_pkg::LVL_IDLE;
          result_o.kind      = flptw_pkg::KIND_DONE;
          result_o.phys_addr = {1'b0, item_i.entry_data[39:12], state_i.vaddr[11:0]};
        end
        default: begin
          state_o.level = flptw_pkg::LVL_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/flptw_out_reg.sv */
// ----------------------------------------------------------------------------
// flptw_out_reg
// result register with valid, refilled in the cycle it is drained
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flptw_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  flptw_pkg::out_item_t data_i,
  input  logic                 take_i,
  output logic                 free_o,
  output logic                 valid_o,
  output flptw_pkg::out_item_t data_o
);

  logic                 valid_q, valid_d;
  flptw_pkg::out_item_t data_q;

  assign free_o  = !valid_q || take_i;
  assign valid_d = load_i || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* sv/four_level_page_table_walker_core.sv */
// ----------------------------------------------------------------------------
// four_level_page_table_walker_core
// x86-64 style four-level page table walker, one step per beat
// ----------------------------------------------------------------------------
//
//   channel  dir  carries
//   in_i     in   start (virtual address, root) or memory response (entry)
//   out_o    out  memory read request or finished translation with status
//
// every in beat yields exactly one out beat; the step is worked out
// combinationally and lands in the result register, so a result shows in the
// cycle after its beat, and a new beat is taken every cycle while out_o takes
// the results; in_i.ready drops only while the result register holds a beat
// that out_o does not take in the same cycle
// reset clears the walk level to idle and empties the result register
`timescale 1ns / 1ps

`include "four_level_page_table_walker_core_assert.svh"

module four_level_page_table_walker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  flptw_in_if.sink    in_i,
  flptw_out_if.source out_o
);

  // walk state: level one-hot, virtual address of the running walk
  flptw_pkg::level_e      level_q;
  logic [flptw_pkg::VA_W-1:0] vaddr_q;
  flptw_pkg::walk_state_t state_cur, state_nxt;

  flptw_pkg::in_item_t    in_item;
  flptw_pkg::out_item_t   step_res, out_q;
  logic                   in_fire;
  logic                   out_free;
  logic                   out_valid;

  // gather the incoming beat
  assign in_item = '{func: flptw_pkg::func_e'(in_i.func), virt_addr: in_i.virt_addr,
                     root_table: in_i.root_table, entry_data: in_i.entry_data};

  assign state_cur = '{level: level_q, vaddr: vaddr_q};

  flptw_step u_step (
    .item_i   (in_item),
    .state_i  (state_cur),
    .state_o  (state_nxt),
    .result_o (step_res)
  );

  // accept whenever the result register frees up this cycle
  assign in_i.ready = out_free;
  assign in_fire    = in_i.valid && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= flptw_pkg::LVL_IDLE;
      vaddr_q <= '0;
    end else if (in_fire) begin
      level_q <= state_nxt.level;
      vaddr_q <= state_nxt.vaddr;
    end
  end

  flptw_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_fire),
    .data_i  (step_res),
    .take_i  (out_o.ready),
    .free_o  (out_free),
    .valid_o (out_valid),
    .data_o  (out_q)
  );

  // drive the result channel from the register
  assign out_o.valid        = out_valid;
  assign out_o.kind         = out_q.kind;
  assign out_o.read_address = out_q.read_address;
  assign out_o.phys_addr    = out_q.phys_addr;
  assign out_o.status       = out_q.status;

  // a start always heads for the pml4 entry
  `FLPTW_ASSERT(a_start_to_pml4, in_fire && (in_item.func == flptw_pkg::FUNC_START) |=> level_q == flptw_pkg::LVL_PML4)
  // a finished translation leaves the walker idle
  `FLPTW_ASSERT(a_done_idle, in_fire && (step_res.kind == flptw_pkg::KIND_DONE) |=> level_q == flptw_pkg::LVL_IDLE)
  // every accepted beat shows up in the result register
  `FLPTW_ASSERT(a_fire_fills, in_fire |=> out_valid)
  // read requests carry no status and no translation
  `FLPTW_ASSERT_ALWAYS(a_read_clean, out_valid && (out_q.kind == flptw_pkg::KIND_READ) |-> (out_q.status == flptw_pkg::ST_OK) && (out_q.phys_addr == '0))

endmodule
